@@ design/pptsch_pkg.sv @@
// Shared types and constants for the periodic priority task scheduler.
`timescale 1ns / 1ps

package pptsch_pkg;

   localparam int PRIO_W   = 8;
   localparam int PERIOD_W = 16;
   localparam int TIME_W   = 32;
   localparam int RUNS_W   = 32;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 4;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 104;

   localparam logic [STATUS_W-1:0] ST_DISPATCH = 2'd0;
   localparam logic [STATUS_W-1:0] ST_IDLE     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ADDED    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_ADD  = 1'b1;

   typedef struct packed {
      logic [PRIO_W-1:0]   prio;
      logic [PERIOD_W-1:0] period;
      logic [TIME_W-1:0]   last_dispatch;
      logic                ready;
      logic [RUNS_W-1:0]   runs;
   } entry_type;

endpackage

@@ design/periodic_priority_task_scheduler.sv @@
// An add item goes from S_IDLE to S_DONE and then into the output register that
// drives rsp_tvalid. A tick item scans one slot per cycle through the registered
// table read port (S_SCAN, S_WAIT), then S_COMMIT and S_DONE; with an empty table
// it goes from S_IDLE straight to S_COMMIT. One item at a time: a new item is taken
// only in S_IDLE, after the last result leaves S_DONE. Synchronous active-high reset
// clears the slot count, time and idle counter; table entries are written on add.
`timescale 1ns / 1ps

module periodic_priority_task_scheduler #(
   parameter int MAX_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [pptsch_pkg::REQ_DATA_W-1:0] req_tdata,  // priority_req, period
   input  logic        req_tuser,                        // kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // slot index, dispatch runs, tick total, idle total, zero fill
   output logic [pptsch_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic [pptsch_pkg::STATUS_W-1:0]   rsp_tuser    // status
);
   import pptsch_pkg::*;

   localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CNT_W = $clog2(MAX_SLOTS + 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_WAIT   = 3'd2;
   localparam logic [2:0] S_COMMIT = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [CNT_W-1:0]    total_ff, total_in;
   logic [TIME_W-1:0]   time_ff, time_in;
   logic [TIME_W-1:0]   idle_ff, idle_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic                proc_valid_ff, proc_valid_in;
   logic [CNT_W-1:0]    proc_slot_ff, proc_slot_in;

   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [CNT_W-1:0]    res_slot_ff, res_slot_in;
   logic [RUNS_W-1:0]   res_runs_ff, res_runs_in;

   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [INDEX_W-1:0]  out_index_ff, out_index_in;
   logic [RUNS_W-1:0]   out_runs_ff, out_runs_in;
   logic [TIME_W-1:0]   out_tick_ff, out_tick_in;
   logic [TIME_W-1:0]   out_idle_ff, out_idle_in;

   logic                accept;
   logic                table_full;
   logic                load_out;
   logic [CNT_W+INDEX_W-1:0] slot_wide;

   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   entry_type           wr_data;
   entry_type           rd_data;
   entry_type           upd_entry;
   entry_type           new_entry;
   entry_type           commit_entry;
   logic                best_found;
   logic [CNT_W-1:0]    best_slot;
   entry_type           best_entry;

   logic [PRIO_W-1:0]   req_prio;
   logic [PERIOD_W-1:0] req_period;

   assign req_prio   = req_tdata[PRIO_W-1:0];
   assign req_period = req_tdata[PRIO_W+PERIOD_W-1:PRIO_W];

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign table_full = (total_ff == CNT_W'(MAX_SLOTS));
   assign load_out   = (state_ff == S_DONE) && (!out_valid_ff || rsp_tready);
   assign slot_wide  = {{INDEX_W{1'b0}}, res_slot_ff};

   pptsch_table #(
      .DEPTH (MAX_SLOTS),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (issue_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   pptsch_scan #(
      .CNT_W (CNT_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .clear      (accept && (req_tuser == KIND_TICK)),
      .proc_valid (proc_valid_ff),
      .proc_slot  (proc_slot_ff),
      .proc_entry (rd_data),
      .time_now   (time_ff),
      .upd_entry  (upd_entry),
      .best_found (best_found),
      .best_slot  (best_slot),
      .best_entry (best_entry)
   );

   always_comb begin
      new_entry.prio          = req_prio;
      new_entry.period        = req_period;
      new_entry.last_dispatch = '0;
      new_entry.ready         = 1'b1;
      new_entry.runs          = '0;

      commit_entry               = best_entry;
      commit_entry.last_dispatch = time_ff;
      commit_entry.runs          = best_entry.runs + 1'b1;
      // A periodic task blocks until its period elapses again.
      commit_entry.ready         = (best_entry.period == '0);
   end

   // Table write port: add, readiness write-back, or dispatch update.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = new_entry;
      if (accept && (req_tuser == KIND_ADD) && !table_full) begin
         wr_en   = 1'b1;
         wr_addr = total_ff[IDX_W-1:0];
      end else if (proc_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = proc_slot_ff[IDX_W-1:0];
         wr_data = upd_entry;
      end else if ((state_ff == S_COMMIT) && best_found) begin
         wr_en   = 1'b1;
         wr_addr = best_slot[IDX_W-1:0];
         wr_data = commit_entry;
      end
   end

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      time_in       = time_ff;
      idle_in       = idle_ff;
      issue_in      = issue_ff;
      proc_valid_in = 1'b0;
      proc_slot_in  = issue_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_runs_in   = res_runs_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_tuser == KIND_ADD) begin
                  res_runs_in = '0;
                  if (table_full) begin
                     res_status_in = ST_FULL;
                     res_slot_in   = '0;
                  end else begin
                     res_status_in = ST_ADDED;
                     res_slot_in   = total_ff;
                     total_in      = total_ff + 1'b1;
                  end
                  state_in = S_DONE;
               end else begin
                  time_in  = time_ff + 1'b1;
                  issue_in = '0;
                  state_in = (total_ff == '0) ? S_COMMIT : S_SCAN;
               end
            end
         end
         S_SCAN: begin
            proc_valid_in = 1'b1;
            issue_in      = issue_ff + 1'b1;
            if (issue_ff == total_ff - 1'b1) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: begin
            // The last slot read is evaluated in this cycle.
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (best_found) begin
               res_status_in = ST_DISPATCH;
               res_slot_in   = best_slot;
               res_runs_in   = commit_entry.runs;
            end else begin
               res_status_in = ST_IDLE;
               res_slot_in   = '0;
               res_runs_in   = '0;
               idle_in       = idle_ff + 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      out_valid_in  = load_out || (out_valid_ff && !rsp_tready);
      out_status_in = out_status_ff;
      out_index_in  = out_index_ff;
      out_runs_in   = out_runs_ff;
      out_tick_in   = out_tick_ff;
      out_idle_in   = out_idle_ff;
      if (load_out) begin
         out_status_in = res_status_ff;
         out_index_in  = slot_wide[INDEX_W-1:0];
         out_runs_in   = res_runs_ff;
         out_tick_in   = time_ff;
         out_idle_in   = idle_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         total_ff      <= '0;
         time_ff       <= '0;
         idle_ff       <= '0;
         issue_ff      <= '0;
         proc_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         time_ff       <= time_in;
         idle_ff       <= idle_in;
         issue_ff      <= issue_in;
         proc_valid_ff <= proc_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      proc_slot_ff  <= proc_slot_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_runs_ff   <= res_runs_in;
      out_status_ff <= out_status_in;
      out_index_ff  <= out_index_in;
      out_runs_ff   <= out_runs_in;
      out_tick_ff   <= out_tick_in;
      out_idle_ff   <= out_idle_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-INDEX_W-RUNS_W-2*TIME_W){1'b0}},
                        out_idle_ff, out_tick_ff, out_runs_ff, out_index_ff};

endmodule

@@ design/pptsch_table.sv @@
// Task table memory: one write port and one registered read port.
`timescale 1ns / 1ps

module pptsch_table #(
   parameter int DEPTH = 16,
   parameter int IDX_W = 4
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [IDX_W-1:0]      wr_addr,
   input  pptsch_pkg::entry_type wr_data,
   input  logic [IDX_W-1:0]      rd_addr,
   output pptsch_pkg::entry_type rd_data
);
   import pptsch_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/pptsch_scan.sv @@
// Per-slot compare unit: refreshes readiness and tracks the best ready task.
`timescale 1ns / 1ps

module pptsch_scan #(
   parameter int CNT_W = 5
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      clear,
   input  logic                      proc_valid,
   input  logic [CNT_W-1:0]          proc_slot,
   input  pptsch_pkg::entry_type     proc_entry,
   input  logic [pptsch_pkg::TIME_W-1:0] time_now,
   output pptsch_pkg::entry_type     upd_entry,
   output logic                      best_found,
   output logic [CNT_W-1:0]          best_slot,
   output pptsch_pkg::entry_type     best_entry
);
   import pptsch_pkg::*;

   logic                found_ff, found_in;
   logic [CNT_W-1:0]    slot_ff, slot_in;
   entry_type           entry_ff, entry_in;
   logic [TIME_W-1:0]   elapsed;
   logic                due;
   logic                ready_now;
   logic                better;

   // Wrapping elapsed time against the period decides whether the task is due.
   always_comb begin
      elapsed   = time_now - proc_entry.last_dispatch;
      due       = (proc_entry.period != '0) &&
                  (elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, proc_entry.period});
      ready_now = proc_entry.ready | due;
      upd_entry = proc_entry;
      upd_entry.ready = ready_now;
      // Strict compare keeps the lowest slot on a tie.
      better = ready_now && (!found_ff || (proc_entry.prio < entry_ff.prio));
   end

   always_comb begin
      found_in = found_ff;
      slot_in  = slot_ff;
      entry_in = entry_ff;
      if (clear) begin
         found_in = 1'b0;
      end else if (proc_valid && better) begin
         found_in = 1'b1;
         slot_in  = proc_slot;
         entry_in = upd_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      slot_ff  <= slot_in;
      entry_ff <= entry_in;
   end

   assign best_found = found_ff;
   assign best_slot  = slot_ff;
   assign best_entry = entry_ff;

endmodule

@@ test/periodic_priority_task_scheduler_tb.sv @@
// Self-checking testbench for the periodic priority task scheduler.
`timescale 1ns / 1ps

module periodic_priority_task_scheduler_tb;
   import pptsch_pkg::*;

   localparam int SLOTS       = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  index;
      logic [RUNS_W-1:0]   runs;
      logic [TIME_W-1:0]   ticks;
      logic [TIME_W-1:0]   idles;
   } sched_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // priority_req, period
   logic                  req_tuser;   // kind
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // slot index, dispatch runs, tick total, idle total, zero fill
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;   // status

   // Predicted scheduler state.
   logic [PRIO_W-1:0]   slot_prio   [SLOTS];
   logic [PERIOD_W-1:0] slot_period [SLOTS];
   logic [TIME_W-1:0]   slot_last   [SLOTS];
   logic                slot_ready  [SLOTS];
   logic [RUNS_W-1:0]   slot_runs   [SLOTS];
   int                  slots_used;
   logic [TIME_W-1:0]   tick_total;
   logic [TIME_W-1:0]   idle_total;

   sched_result_type expected_q[$];
   int               mismatch_count;
   int               cycle_count;
   bit               gaps_on;
   int               stall_left;

   periodic_priority_task_scheduler #(
      .MAX_SLOTS(SLOTS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic sched_result_type predict_schedule(input logic kind,
         input logic [PRIO_W-1:0] prio, input logic [PERIOD_W-1:0] per);
      sched_result_type  r;
      logic [TIME_W-1:0] elapsed;
      int                best;
      r = '0;
      if (kind == KIND_ADD) begin
         if (slots_used >= SLOTS) begin
            r.status = ST_FULL;
         end else begin
            slot_prio[slots_used]   = prio;
            slot_period[slots_used] = per;
            slot_last[slots_used]   = '0;
            slot_ready[slots_used]  = 1'b1;
            slot_runs[slots_used]   = '0;
            r.status = ST_ADDED;
            r.index  = slots_used[INDEX_W-1:0];
            slots_used++;
         end
      end else begin
         tick_total = tick_total + 1'b1;
         for (int i = 0; i < slots_used; i++) begin
            if (slot_period[i] != '0) begin
               elapsed = tick_total - slot_last[i];
               if (elapsed >= {16'b0, slot_period[i]}) slot_ready[i] = 1'b1;
            end
         end
         best = -1;
         for (int i = 0; i < slots_used; i++) begin
            if (slot_ready[i] && (best < 0 || slot_prio[i] < slot_prio[best])) best = i;
         end
         if (best >= 0) begin
            slot_last[best] = tick_total;
            slot_runs[best] = slot_runs[best] + 1'b1;
            // Periodic tasks sleep until their period comes around again.
            if (slot_period[best] != '0) slot_ready[best] = 1'b0;
            r.status = ST_DISPATCH;
            r.index  = best[INDEX_W-1:0];
            r.runs   = slot_runs[best];
         end else begin
            idle_total = idle_total + 1'b1;
            r.status   = ST_IDLE;
         end
      end
      r.ticks = tick_total;
      r.idles = idle_total;
      return r;
   endfunction

   function automatic void note_mismatch(input string what, input logic [31:0] want,
         input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX)
         $display("mismatch in %s: expected %0h, got %0h", what, want, got);
   endfunction

   // Sends one item; valid stays high from one item to the next unless a gap is taken.
   task automatic send_item(input logic kind, input logic [PRIO_W-1:0] prio,
         input logic [PERIOD_W-1:0] per);
      if (gaps_on && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < 85);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {per, prio};
      do @(posedge clock); while (!req_tready);
      expected_q.push_back(predict_schedule(kind, prio, per));
   endtask

   task automatic send_tick();
      logic [REQ_DATA_W-1:0] noise;
      noise = REQ_DATA_W'($urandom);
      send_item(KIND_TICK, noise[PRIO_W-1:0], noise[REQ_DATA_W-1:PRIO_W]);
   endtask

   task automatic wait_drained();
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   // Idle ticks, extremes of priority, the largest period, a priority tie, and a
   // periodic task going blocked and becoming ready again.
   task automatic test_directed_schedule();
      send_tick();
      send_tick();
      send_item(KIND_ADD, 8'hFF, 16'hFFFF);
      send_item(KIND_ADD, 8'h00, 16'd5);
      send_item(KIND_ADD, 8'd100, 16'd4);
      send_item(KIND_ADD, 8'd100, 16'd4);
      repeat (10) send_tick();
   endtask

   // The receiver holds off while the sender keeps offering items.
   task automatic test_output_stall();
      stall_left = 300;
      repeat (30) send_tick();
   endtask

   // The sender waits for every outstanding result before going on.
   task automatic test_drain_pause();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait_drained();
      repeat (10) send_tick();
   endtask

   task automatic test_random_traffic(input int count);
      logic [PRIO_W-1:0]   prio;
      logic [PERIOD_W-1:0] per;
      int                  pick;
      for (int k = 0; k < count; k++) begin
         gaps_on = !(k >= count / 3 && k < count / 2);
         if ($urandom_range(0, 99) < 8) begin
            prio = PRIO_W'($urandom);
            pick = $urandom_range(0, 15);
            if (pick == 0) begin
               // An always-runnable task with an urgent priority would starve the rest.
               per  = '0;
               prio = PRIO_W'($urandom_range(128, 255));
            end else if (pick <= 2) begin
               per = PERIOD_W'($urandom_range(1, 65535));
            end else begin
               per = PERIOD_W'($urandom_range(1, 40));
            end
            send_item(KIND_ADD, prio, per);
         end else begin
            send_tick();
         end
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_table_full();
      logic [REQ_DATA_W-1:0] noise;
      while (slots_used < SLOTS) send_item(KIND_ADD, 8'd200, 16'd9);
      repeat (3) begin
         noise = REQ_DATA_W'($urandom);
         send_item(KIND_ADD, noise[PRIO_W-1:0], noise[REQ_DATA_W-1:PRIO_W]);
      end
      send_tick();
   endtask

   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_tready <= gaps_on ? ($urandom_range(0, 99) >= 25) : 1'b1;
      end
   end

   always @(posedge clock) begin : check_results
      sched_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_q.size() == 0) begin
            note_mismatch("result with none expected", '0, 32'(rsp_tuser));
         end else begin
            want = expected_q.pop_front();
            if (rsp_tuser != want.status)
               note_mismatch("status", 32'(want.status), 32'(rsp_tuser));
            if (rsp_tdata[3:0] != want.index)
               note_mismatch("task_index", 32'(want.index), 32'(rsp_tdata[3:0]));
            if (rsp_tdata[35:4] != want.runs)
               note_mismatch("dispatch runs", want.runs, rsp_tdata[35:4]);
            if (rsp_tdata[67:36] != want.ticks)
               note_mismatch("tick total", want.ticks, rsp_tdata[67:36]);
            if (rsp_tdata[99:68] != want.idles)
               note_mismatch("idle_count", want.idles, rsp_tdata[99:68]);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("periodic_priority_task_scheduler regression: fail");
         $finish;
      end
   end

   initial begin
      slots_used     = 0;
      tick_total     = '0;
      idle_total     = '0;
      mismatch_count = 0;
      cycle_count    = 0;
      stall_left     = 0;
      gaps_on        = 1'b1;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= KIND_TICK;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_directed_schedule();
      test_output_stall();
      test_drain_pause();
      test_random_traffic(880);
      test_table_full();

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("periodic_priority_task_scheduler regression: pass");
      end else begin
         $display("periodic_priority_task_scheduler regression: fail");
      end
      $finish;
   end

endmodule
